/* hw/rtl/cosr_pkg.sv */
// Shared types, constants and saturation helpers of the residual stencil.
`default_nettype none

package cosr_pkg;

  // Grid geometry. The side is a power of two, so coordinates are bit fields of the index.
  localparam int SIDE        = 32;
  localparam int COORD_W     = $clog2(SIDE);
  localparam int VOXELS      = SIDE * SIDE * SIDE;
  localparam int ADDR_W      = 3 * COORD_W;
  localparam int NUM_COMP    = 6;
  localparam int NUM_NB      = 6;
  localparam int WORD_W      = 32 * NUM_COMP;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W   = 3;

  // Neighbor order of the stencil.
  localparam logic [2:0] NB_IP = 3'd0;
  localparam logic [2:0] NB_IM = 3'd1;
  localparam logic [2:0] NB_JP = 3'd2;
  localparam logic [2:0] NB_JM = 3'd3;
  localparam logic [2:0] NB_KP = 3'd4;
  localparam logic [2:0] NB_KM = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MASS_SQ         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THETA_MASS_SQ   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POT_COUPLING    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POT_SATURATION  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CURL_COUPLING   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING_SQ  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_TWO_SPACING = 3'd6;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // The Laplacian sum reaches twelve full-scale words, so it needs 36 bits.
  typedef logic signed [31:0] q16_t;
  typedef logic signed [35:0] acc_t;
  typedef logic signed [46:0] w47_t;
  typedef logic signed [47:0] w48_t;
  typedef logic signed [63:0] w64_t;

  localparam w64_t LIM46 = 64'sh0000_3FFF_FFFF_FFFF;
  localparam w64_t Q_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam w64_t Q_MIN = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    op_t         op;
    logic [14:0] voxel;
    q16_t        phi_x;
    q16_t        phi_y;
    q16_t        phi_z;
    q16_t        theta_x;
    q16_t        theta_y;
    q16_t        theta_z;
  } in_item_t;

  typedef struct packed {
    logic [14:0] out_voxel;
    q16_t        res_phi_x;
    q16_t        res_phi_y;
    q16_t        res_phi_z;
    q16_t        res_theta_x;
    q16_t        res_theta_y;
    q16_t        res_theta_z;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    op_t                           op;
    logic                          in_range;
    logic [14:0]                   voxel;
    logic [ADDR_W-1:0]             addr;
    logic [NUM_NB-1:0][ADDR_W-1:0] nb;
    logic [WORD_W-1:0]             data;
  } cmd_t;

  typedef struct packed {
    q16_t        mass_sq;
    q16_t        theta_mass_sq;
    q16_t        pot_coupling;
    q16_t        pot_saturation;
    q16_t        curl_coupling;
    logic [30:0] inv_spacing_sq;
    logic [30:0] inv_two_spacing;
  } cfg_t;

  typedef struct packed {
    logic mul_start;
    w48_t mul_a;
    q16_t mul_b;
    logic div_start;
    q16_t div_n;
    w48_t div_d;
  } arith_req_t;

  typedef struct packed {
    logic mul_done;
    w64_t mul_res;
    logic div_done;
    q16_t div_res;
  } arith_rsp_t;

  function automatic w47_t sat46(input w64_t x);
    w47_t r;
    if (x > LIM46) r = 47'(LIM46);
    else if (x < -LIM46) r = 47'(-LIM46);
    else r = 47'(x);
    return r;
  endfunction

  function automatic q16_t sat32(input w64_t x);
    q16_t r;
    if (x > Q_MAX) r = 32'(Q_MAX);
    else if (x < Q_MIN) r = 32'(Q_MIN);
    else r = 32'(x);
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/cosr_front.sv */
// Front end: range check, coordinate split and periodic neighbor addresses.
`default_nettype none

module cosr_front import cosr_pkg::*; (
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  input  wire logic     q_full,
  output logic          push,
  output cmd_t          push_item
);

  logic [ADDR_W-1:0]  addr;
  logic [COORD_W-1:0] ci, cj, ck, ip, im, jp, jm, kp, km;

  // Split the index into coordinates and wrap each one both ways.
  always_comb begin
    addr = ADDR_W'(in_data.voxel);
    ck = addr[COORD_W-1:0];
    cj = addr[2*COORD_W-1:COORD_W];
    ci = addr[3*COORD_W-1:2*COORD_W];
    ip = (ci == COORD_W'(SIDE - 1)) ? '0 : ci + 1'b1;
    im = (ci == '0) ? COORD_W'(SIDE - 1) : ci - 1'b1;
    jp = (cj == COORD_W'(SIDE - 1)) ? '0 : cj + 1'b1;
    jm = (cj == '0) ? COORD_W'(SIDE - 1) : cj - 1'b1;
    kp = (ck == COORD_W'(SIDE - 1)) ? '0 : ck + 1'b1;
    km = (ck == '0) ? COORD_W'(SIDE - 1) : ck - 1'b1;
  end

  // Build the command word for the queue.
  always_comb begin
    push_item          = '0;
    push_item.op       = in_data.op;
    push_item.in_range = (32'(in_data.voxel) < VOXELS);
    push_item.voxel    = in_data.voxel;
    push_item.addr     = addr;
    push_item.nb[NB_IP] = {ip, cj, ck};
    push_item.nb[NB_IM] = {im, cj, ck};
    push_item.nb[NB_JP] = {ci, jp, ck};
    push_item.nb[NB_JM] = {ci, jm, ck};
    push_item.nb[NB_KP] = {ci, cj, kp};
    push_item.nb[NB_KM] = {ci, cj, km};
    push_item.data = {in_data.theta_z, in_data.theta_y, in_data.theta_x,
                      in_data.phi_z, in_data.phi_y, in_data.phi_x};
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

endmodule

`default_nettype wire

/* hw/rtl/cosr_fifo.sv */
// Short command queue between the front end and the back end.
`default_nettype none

module cosr_fifo import cosr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_item,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output cmd_t      head
);

  cmd_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_pop;

  assign full      = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  // Storage of the queued words.
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/cosr_arith.sv */
// Shared arithmetic: a multi-cycle Q16.16 multiplier and a radix-2 divider.
`default_nettype none

module cosr_arith import cosr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire arith_req_t req,
  output arith_rsp_t      rsp
);

  localparam int DIV_STEPS = 48;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // Multiplier: 48 x 32 bits as two 25 x 32 partial products.
  w48_t               ma_r;
  q16_t               mb_r;
  logic [1:0]         mph_r;
  logic               mbusy_r, mdone_r;
  logic signed [24:0] mopa;
  logic signed [56:0] mprod, plo_r;
  logic signed [55:0] phi_r;
  logic signed [79:0] msum;
  w64_t               mres_r;

  always_comb begin
    mopa  = (mph_r == 2'd0) ? $signed({1'b0, ma_r[23:0]}) : $signed({ma_r[47], ma_r[47:24]});
    mprod = mopa * mb_r;
    msum  = $signed({phi_r, 24'd0}) + 80'(plo_r);
  end

  always_ff @(posedge clk) begin
    if (req.mul_start) begin
      ma_r <= req.mul_a;
      mb_r <= req.mul_b;
    end
    if (mbusy_r && mph_r == 2'd0) plo_r <= mprod;
    if (mbusy_r && mph_r == 2'd1) phi_r <= mprod[55:0];
    if (mbusy_r && mph_r == 2'd2) mres_r <= msum[79:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      mph_r   <= 2'd0;
      mdone_r <= 1'b0;
    end else begin
      mdone_r <= mbusy_r && (mph_r == 2'd2);
      if (req.mul_start) begin
        mbusy_r <= 1'b1;
        mph_r   <= 2'd0;
      end else if (mbusy_r) begin
        mph_r <= mph_r + 1'b1;
        if (mph_r == 2'd2) mbusy_r <= 1'b0;
      end
    end
  end

  // Divider: trunc(n * 2^16 / d) on magnitudes, one quotient bit a cycle.
  logic [31:0]       nabs;
  logic [47:0]       dabs;
  logic [47:0]       dquo_r, drem_r, dden_r;
  logic [48:0]       rtry;
  logic              dneg_r, dbusy_r, dfin_r, ddone_r;
  logic [DCNT_W-1:0] dcnt_r;
  q16_t              dres_r, dres_nxt, dzero;

  always_comb begin
    nabs = req.div_n[31] ? ~req.div_n + 1'b1 : req.div_n;
    dabs = req.div_d[47] ? ~req.div_d + 1'b1 : req.div_d;
    rtry = {drem_r, dquo_r[47]};
    if (req.div_n[31]) dzero = 32'(Q_MIN);
    else if (req.div_n != '0) dzero = 32'(Q_MAX);
    else dzero = '0;
    if (!dneg_r) begin
      dres_nxt = (dquo_r > 48'h0000_7FFF_FFFF) ? 32'(Q_MAX) : dquo_r[31:0];
    end else begin
      dres_nxt = (dquo_r > 48'h0000_8000_0000) ? 32'(Q_MIN) : ~dquo_r[31:0] + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.div_start) begin
      dquo_r <= {nabs, 16'd0};
      drem_r <= '0;
      dden_r <= dabs;
      dneg_r <= req.div_n[31] ^ req.div_d[47];
      dcnt_r <= '0;
      if (req.div_d == '0) dres_r <= dzero;
    end else if (dbusy_r) begin
      dcnt_r <= dcnt_r + 1'b1;
      if (rtry >= {1'b0, dden_r}) begin
        drem_r <= 48'(rtry - {1'b0, dden_r});
        dquo_r <= {dquo_r[46:0], 1'b1};
      end else begin
        drem_r <= rtry[47:0];
        dquo_r <= {dquo_r[46:0], 1'b0};
      end
    end else if (dfin_r) begin
      dres_r <= dres_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      dfin_r  <= 1'b0;
      ddone_r <= 1'b0;
    end else begin
      ddone_r <= dfin_r || (req.div_start && req.div_d == '0);
      dfin_r  <= dbusy_r && (dcnt_r == DCNT_W'(DIV_STEPS - 1));
      if (req.div_start) dbusy_r <= (req.div_d != '0);
      else if (dbusy_r && dcnt_r == DCNT_W'(DIV_STEPS - 1)) dbusy_r <= 1'b0;
    end
  end

  always_comb begin
    rsp.mul_done = mdone_r;
    rsp.mul_res  = mres_r;
    rsp.div_done = ddone_r;
    rsp.div_res  = dres_r;
  end

endmodule

`default_nettype wire

/* hw/rtl/cosr_back.sv */
// Back end: voxel memory, stencil gather and the residual sequencer.
`default_nettype none

module cosr_back import cosr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       q_valid,
  input  wire cmd_t       q_item,
  output logic            q_pop,
  output arith_req_t      req,
  input  wire arith_rsp_t rsp,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_data
);

  // Sequencer step numbers.
  localparam logic [5:0] ST_LAP   = 6'd0;
  localparam logic [5:0] ST_MASS  = 6'd6;
  localparam logic [5:0] ST_CURL1 = 6'd12;
  localparam logic [5:0] ST_CURL2 = 6'd18;
  localparam logic [5:0] ST_PXY   = 6'd24;
  localparam logic [5:0] ST_P     = 6'd25;
  localparam logic [5:0] ST_PP    = 6'd26;
  localparam logic [5:0] ST_DEN   = 6'd27;
  localparam logic [5:0] ST_Q1    = 6'd28;
  localparam logic [5:0] ST_Q2    = 6'd29;
  localparam logic [5:0] ST_DV    = 6'd30;
  localparam logic [5:0] ST_DP    = 6'd31;
  localparam logic [5:0] ST_FORCE = 6'd34;
  localparam logic [5:0] ST_LAST  = 6'd36;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_CALC = 5'b00100,
    S_WAIT = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Voxel memory, one word of six components per voxel.
  logic [WORD_W-1:0] mem [VOXELS];
  logic [WORD_W-1:0] rd_data_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] raddr;

  // Query context and gather state.
  logic [14:0]                   voxel_r;
  logic [ADDR_W-1:0]             addr_r;
  logic [NUM_NB-1:0][ADDR_W-1:0] nb_r;
  logic                          zero_r;
  logic [2:0]                    iss_r, rd_sel_r, nb_sel, nbi;
  logic                          rd_vld_r;
  logic [5:0]                    step_r;

  q16_t c_r [NUM_COMP];
  q16_t w [NUM_COMP];
  acc_t lap_acc_r [NUM_COMP], lap_acc_nxt [NUM_COMP];
  acc_t d_r [NUM_COMP], d_nxt [NUM_COMP];

  // Intermediate results.
  w47_t lap_r [NUM_COMP];
  w47_t mass_r [NUM_COMP];
  w47_t cu_r [NUM_COMP];
  w47_t tmp_r, dv_r;
  q16_t p_r, q_r;
  w48_t pp_r, den_r;
  q16_t dp_r [3];
  w47_t force_r [3];

  logic [2:0] lane, partner;
  logic       is_div, wb;
  q16_t       isq, its;
  w64_t       fsum [NUM_COMP];
  q16_t       res [NUM_COMP];
  logic       out_load;
  out_item_t  out_r;
  logic       out_valid_r;

  assign isq = $signed({1'b0, cfg.inv_spacing_sq});
  assign its = $signed({1'b0, cfg.inv_two_spacing});

  // Queue handling and memory access.
  always_comb begin
    q_pop  = (state_r == S_IDLE);
    mem_we = (state_r == S_IDLE) && q_valid && (q_item.op == OP_WRITE) && q_item.in_range;
    mem_re = (state_r == S_READ) && (iss_r <= 3'(NUM_NB));
    nb_sel = (iss_r == 3'd0) ? 3'd0 : iss_r - 3'd1;
    raddr  = (iss_r == 3'd0) ? addr_r : nb_r[nb_sel];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[q_item.addr] <= q_item.data;
    if (mem_re) rd_data_r <= mem[raddr];
  end

  // Gather: center seeds the sums, each neighbor adds to Laplacian and curl sums.
  always_comb begin
    int b;
    b   = 0;
    nbi = rd_sel_r - 3'd1;
    for (int f = 0; f < NUM_COMP; f++) begin
      w[f]           = rd_data_r[f*32 +: 32];
      lap_acc_nxt[f] = lap_acc_r[f] + acc_t'(w[f]);
      d_nxt[f]       = d_r[f];
    end
    if (rd_sel_r == 3'd0) begin
      for (int f = 0; f < NUM_COMP; f++) begin
        lap_acc_nxt[f] = acc_t'(0) - acc_t'(w[f]) * 36'sd6;
        d_nxt[f]       = '0;
      end
    end else begin
      for (int h = 0; h < 2; h++) begin
        b = 3 * h;
        case (nbi)
          NB_IP: begin
            d_nxt[b+1] = d_nxt[b+1] - acc_t'(w[b+2]);
            d_nxt[b+2] = d_nxt[b+2] + acc_t'(w[b+1]);
          end
          NB_IM: begin
            d_nxt[b+1] = d_nxt[b+1] + acc_t'(w[b+2]);
            d_nxt[b+2] = d_nxt[b+2] - acc_t'(w[b+1]);
          end
          NB_JP: begin
            d_nxt[b]   = d_nxt[b] + acc_t'(w[b+2]);
            d_nxt[b+2] = d_nxt[b+2] - acc_t'(w[b]);
          end
          NB_JM: begin
            d_nxt[b]   = d_nxt[b] - acc_t'(w[b+2]);
            d_nxt[b+2] = d_nxt[b+2] + acc_t'(w[b]);
          end
          NB_KP: begin
            d_nxt[b]   = d_nxt[b] - acc_t'(w[b+1]);
            d_nxt[b+1] = d_nxt[b+1] + acc_t'(w[b]);
          end
          NB_KM: begin
            d_nxt[b]   = d_nxt[b] + acc_t'(w[b+1]);
            d_nxt[b+1] = d_nxt[b+1] - acc_t'(w[b]);
          end
          default: ;
        endcase
      end
    end
  end

  // Operand selection for the current sequencer step.
  always_comb begin
    req     = '0;
    lane    = '0;
    is_div  = 1'b0;
    if (step_r < ST_MASS) begin
      lane      = 3'(step_r - ST_LAP);
      req.mul_a = 48'(lap_acc_r[lane]);
      req.mul_b = isq;
    end else if (step_r < ST_CURL1) begin
      lane      = 3'(step_r - ST_MASS);
      req.mul_a = 48'(c_r[lane]);
      req.mul_b = (lane < 3'd3) ? cfg.mass_sq : cfg.theta_mass_sq;
    end else if (step_r < ST_CURL2) begin
      lane      = 3'(step_r - ST_CURL1);
      req.mul_b = its;
    end else if (step_r < ST_PXY) begin
      lane      = 3'(step_r - ST_CURL2);
      req.mul_a = 48'(cu_r[lane]);
      req.mul_b = cfg.curl_coupling;
    end else if (step_r == ST_PXY) begin
      req.mul_a = 48'(c_r[0]);
      req.mul_b = c_r[1];
    end else if (step_r == ST_P) begin
      req.mul_a = 48'(tmp_r);
      req.mul_b = c_r[2];
    end else if (step_r == ST_PP) begin
      req.mul_a = 48'(p_r);
      req.mul_b = p_r;
    end else if (step_r == ST_DEN) begin
      req.mul_a = pp_r;
      req.mul_b = cfg.pot_saturation;
    end else if (step_r == ST_Q1 || step_r == ST_Q2) begin
      is_div    = 1'b1;
      req.div_n = (step_r == ST_Q1) ? p_r : q_r;
      req.div_d = den_r;
    end else if (step_r == ST_DV) begin
      req.mul_a = 48'(q_r);
      req.mul_b = cfg.pot_coupling;
    end else if (step_r < ST_FORCE) begin
      lane      = 3'(step_r - ST_DP);
      req.mul_a = (lane == 3'd0) ? 48'(c_r[1]) : 48'(c_r[0]);
      req.mul_b = (lane == 3'd2) ? c_r[1] : c_r[2];
    end else begin
      lane      = 3'(step_r - ST_FORCE);
      req.mul_a = 48'(dv_r);
      req.mul_b = (lane < 3'd3) ? dp_r[lane[1:0]] : '0;
    end
    // Phi takes the curl of theta and theta the curl of phi.
    partner = (lane < 3'd3) ? lane + 3'd3 : lane - 3'd3;
    if (step_r >= ST_CURL1 && step_r < ST_CURL2) req.mul_a = 48'(d_r[partner]);
    req.mul_start = (state_r == S_CALC) && !is_div;
    req.div_start = (state_r == S_CALC) && is_div;
  end

  assign wb = (state_r == S_WAIT) && (rsp.mul_done || rsp.div_done);

  // Capture of gathered words and of unit results.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && q_valid && q_item.op == OP_QUERY) begin
      voxel_r <= q_item.voxel;
      addr_r  <= q_item.addr;
      nb_r    <= q_item.nb;
      zero_r  <= !q_item.in_range;
    end
    if (rd_vld_r) begin
      for (int f = 0; f < NUM_COMP; f++) begin
        lap_acc_r[f] <= lap_acc_nxt[f];
        d_r[f]       <= d_nxt[f];
        if (rd_sel_r == 3'd0) c_r[f] <= w[f];
      end
    end
    if (wb) begin
      if (step_r < ST_MASS) lap_r[lane] <= sat46(rsp.mul_res);
      else if (step_r < ST_CURL1) mass_r[lane] <= sat46(rsp.mul_res);
      else if (step_r < ST_PXY) cu_r[lane] <= sat46(rsp.mul_res);
      else if (step_r == ST_PXY) tmp_r <= sat46(rsp.mul_res);
      else if (step_r == ST_P) p_r <= sat32(rsp.mul_res);
      else if (step_r == ST_PP) pp_r <= rsp.mul_res[47:0];
      else if (step_r == ST_DEN) den_r <= 48'(sat46(rsp.mul_res)) + 48'sd65536;
      else if (step_r == ST_Q1 || step_r == ST_Q2) q_r <= rsp.div_res;
      else if (step_r == ST_DV) dv_r <= sat46(rsp.mul_res);
      else if (step_r < ST_FORCE) dp_r[lane[1:0]] <= sat32(rsp.mul_res);
      else force_r[lane[1:0]] <= sat46(rsp.mul_res);
    end
  end

  // Final sums of the six residuals.
  always_comb begin
    for (int f = 0; f < 3; f++) begin
      fsum[f] = 64'(lap_r[f]) - 64'(mass_r[f]) - 64'(force_r[f]) + 64'(cu_r[f]);
    end
    for (int f = 3; f < NUM_COMP; f++) begin
      fsum[f] = 64'(lap_r[f]) - 64'(mass_r[f]) + 64'(cu_r[f]);
    end
    for (int f = 0; f < NUM_COMP; f++) begin
      res[f] = zero_r ? '0 : sat32(fsum[f]);
    end
  end

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.out_voxel   <= voxel_r;
      out_r.res_phi_x   <= res[0];
      out_r.res_phi_y   <= res[1];
      out_r.res_phi_z   <= res[2];
      out_r.res_theta_x <= res[3];
      out_r.res_theta_y <= res[4];
      out_r.res_theta_z <= res[5];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid && q_item.op == OP_QUERY) begin
          state_nxt = q_item.in_range ? S_READ : S_DONE;
        end
      end
      S_READ: if (rd_vld_r && rd_sel_r == 3'(NUM_NB)) state_nxt = S_CALC;
      S_CALC: state_nxt = S_WAIT;
      S_WAIT: if (wb) state_nxt = (step_r == ST_LAST) ? S_DONE : S_CALC;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      iss_r       <= '0;
      rd_sel_r    <= '0;
      step_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= mem_re;
      if (mem_re) begin
        rd_sel_r <= iss_r;
        iss_r    <= iss_r + 1'b1;
      end
      if (state_r == S_IDLE) begin
        iss_r  <= '0;
        step_r <= ST_LAP;
      end
      if (wb) step_r <= step_r + 1'b1;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* hw/rtl/cosserat_residual_stencil.sv */
// Top level of the residual stencil: configuration registers and block wiring.
`default_nettype none

// Holds a periodic cubic grid of six-component Q16.16 voxels in one memory word per voxel.
// A write word stores a voxel once it leaves the two-entry command queue. A query word
// reads the center and its six neighbors through the single memory read port, then a
// sequencer runs 35 multiplications through one shared multiplier and two divisions
// through a one-bit-per-cycle divider. Out-of-grid queries answer with zero residuals.
// Results sit in an output register, so the back end can go on taking words from the
// queue while a result waits, until its next result is ready.
module cosserat_residual_stencil import cosr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  cfg_t       cfg_r;
  logic       q_full, push, q_pop, q_valid;
  cmd_t       push_item, q_head;
  arith_req_t req;
  arith_rsp_t rsp;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mass_sq         <= 32'sd147456;
      cfg_r.theta_mass_sq   <= 32'sd0;
      cfg_r.pot_coupling    <= -32'sd2709586;
      cfg_r.pot_saturation  <= 32'sd3276800;
      cfg_r.curl_coupling   <= 32'sd32768;
      cfg_r.inv_spacing_sq  <= 31'd65536;
      cfg_r.inv_two_spacing <= 31'd32768;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MASS_SQ:         cfg_r.mass_sq         <= cfg_data;
        CFG_THETA_MASS_SQ:   cfg_r.theta_mass_sq   <= cfg_data;
        CFG_POT_COUPLING:    cfg_r.pot_coupling    <= cfg_data;
        CFG_POT_SATURATION:  cfg_r.pot_saturation  <= cfg_data;
        CFG_CURL_COUPLING:   cfg_r.curl_coupling   <= cfg_data;
        CFG_INV_SPACING_SQ:  cfg_r.inv_spacing_sq  <= cfg_data[30:0];
        CFG_INV_TWO_SPACING: cfg_r.inv_two_spacing <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  cosr_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  cosr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  cosr_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  cosr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .req       (req),
    .rsp       (rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* verif/tb_cosserat_residual_stencil.sv */
// Self-checking testbench for the Cosserat residual stencil: write and query words checked against a predictor.
`default_nettype none

module tb_cosserat_residual_stencil import cosr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 2000;
  localparam int SETTLE_CYCLES = 400;
  localparam int PHASE_WORDS = 200;
  localparam int NUM_PHASES = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  localparam longint Q_HI = 64'sh7FFF_FFFF;
  localparam longint Q_LO = -64'sh8000_0000;
  localparam longint L46 = 64'sh3FFF_FFFF_FFFF;
  localparam q16_t QMAX = 32'sh7FFF_FFFF;
  localparam q16_t QMIN = 32'sh8000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  cosserat_residual_stencil dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: shadow of the field memory and of the coefficient registers.
  int field_mem [VOXELS][NUM_COMP];
  bit voxel_written [VOXELS];
  longint coef [7];
  out_item_t pending_res [$];
  int errors = 0;
  int words_sent = 0;
  bit idle_on = 1'b1;
  bit long_hold = 1'b0;

  // Directed stimulus: one value for all phi components and one for all theta components.
  typedef struct packed {
    op_t         op;
    logic [14:0] vox;
    q16_t        phi;
    q16_t        theta;
    logic        typed;
    q16_t        res;
  } dir_row_t;

  localparam int DIR_ROWS = 20;
  localparam dir_row_t DIR [DIR_ROWS] = '{
    // Zero neighborhood around the corner voxel, which wraps on every axis.
    '{OP_WRITE, 15'd0,     32'sd0, 32'sd0, 1'b0, 32'sd0},
    '{OP_WRITE, 15'd1,     32'sd0, 32'sd0, 1'b0, 32'sd0},
    '{OP_WRITE, 15'd31,    32'sd0, 32'sd0, 1'b0, 32'sd0},
    '{OP_WRITE, 15'd32,    32'sd0, 32'sd0, 1'b0, 32'sd0},
    '{OP_WRITE, 15'd992,   32'sd0, 32'sd0, 1'b0, 32'sd0},
    '{OP_WRITE, 15'd1024,  32'sd0, 32'sd0, 1'b0, 32'sd0},
    '{OP_WRITE, 15'd31744, 32'sd0, 32'sd0, 1'b0, 32'sd0},
    '{OP_QUERY, 15'd0,     32'sd0, 32'sd0, 1'b1, 32'sd0},
    // A full-scale center against zero neighbors saturates every residual.
    '{OP_WRITE, 15'd0,     QMAX,   QMAX,   1'b0, 32'sd0},
    '{OP_QUERY, 15'd0,     32'sd0, 32'sd0, 1'b1, QMIN},
    '{OP_WRITE, 15'd0,     QMIN,   QMIN,   1'b0, 32'sd0},
    '{OP_QUERY, 15'd0,     32'sd0, 32'sd0, 1'b1, QMAX},
    // Mixed extremes around the last voxel of the grid.
    '{OP_WRITE, 15'd1023,  QMAX,   QMIN,   1'b0, 32'sd0},
    '{OP_WRITE, 15'd31743, QMIN,   QMAX,   1'b0, 32'sd0},
    '{OP_WRITE, 15'd31775, -32'sd65536, 32'sd131072, 1'b0, 32'sd0},
    '{OP_WRITE, 15'd32735, 32'sh0001_8000, -32'sd1, 1'b0, 32'sd0},
    '{OP_WRITE, 15'd32736, 32'sd1, 32'sh7FFF_0000, 1'b0, 32'sd0},
    '{OP_WRITE, 15'd32766, -32'sh7FFF_0000, 32'sd65536, 1'b0, 32'sd0},
    '{OP_WRITE, 15'd32767, 32'sh0002_0000, -32'sd65536, 1'b0, 32'sd0},
    '{OP_QUERY, 15'd32767, 32'sd0, 32'sd0, 1'b0, 32'sd0}
  };

  function automatic longint clamp46(longint x);
    return x > L46 ? L46 : (x < -L46 ? -L46 : x);
  endfunction

  function automatic longint clamp32(longint x);
    return x > Q_HI ? Q_HI : (x < Q_LO ? Q_LO : x);
  endfunction

  // Floor of a*b/2^16, split so that no partial product overflows 64 bits.
  function automatic longint qmul(longint a, longint b);
    longint hi;
    longint lo;
    hi = a >>> 16;
    lo = a - (hi <<< 16);
    return hi * b + ((lo * b) >>> 16);
  endfunction

  function automatic longint qdiv(longint n, longint d);
    if (d == 0) return n > 0 ? Q_HI : (n < 0 ? Q_LO : 0);
    return clamp32((n * 65536) / d);
  endfunction

  // Neighbor n of a voxel (0 is the voxel itself, then +i, -i, +j, -j, +k, -k), periodic.
  function automatic logic [14:0] nb_of(logic [14:0] v, int n);
    logic [4:0] i;
    logic [4:0] j;
    logic [4:0] k;
    i = v[14:10];
    j = v[9:5];
    k = v[4:0];
    case (n)
      1: i = i + 5'd1;
      2: i = i - 5'd1;
      3: j = j + 5'd1;
      4: j = j - 5'd1;
      5: k = k + 5'd1;
      6: k = k - 5'd1;
      default: ;
    endcase
    return {i, j, k};
  endfunction

  function automatic longint fv(logic [14:0] v, int n, int comp);
    return longint'(field_mem[nb_of(v, n)][comp]);
  endfunction

  // Residuals of one voxel from the shadow memory and coefficients.
  function automatic out_item_t predict_residuals(logic [14:0] v);
    longint c [6];
    longint d [6];
    longint res [6];
    longint p, den, dv, frc, lap, cu, s, dp;
    out_item_t r;
    for (int f = 0; f < 6; f++) c[f] = fv(v, 0, f);
    for (int f = 0; f < 6; f += 3) begin
      d[f]   = fv(v, 3, f+2) - fv(v, 4, f+2) - fv(v, 5, f+1) + fv(v, 6, f+1);
      d[f+1] = fv(v, 5, f)   - fv(v, 6, f)   - fv(v, 1, f+2) + fv(v, 2, f+2);
      d[f+2] = fv(v, 1, f+1) - fv(v, 2, f+1) - fv(v, 3, f)   + fv(v, 4, f);
    end
    p = clamp32(qmul(clamp46(qmul(c[0], c[1])), c[2]));
    den = 65536 + clamp46(qmul(qmul(p, p), coef[CFG_POT_SATURATION]));
    dv = clamp46(qmul(qdiv(qdiv(p, den), den), coef[CFG_POT_COUPLING]));
    for (int f = 0; f < 6; f++) begin
      s = -6 * c[f];
      for (int n = 1; n <= 6; n++) s += fv(v, n, f);
      lap = clamp46(qmul(s, coef[CFG_INV_SPACING_SQ]));
      // Each field couples to the curl of the other one.
      cu = clamp46(qmul(clamp46(qmul(d[f < 3 ? f + 3 : f - 3], coef[CFG_INV_TWO_SPACING])),
                        coef[CFG_CURL_COUPLING]));
      if (f < 3) begin
        dp = (f == 0) ? qmul(c[1], c[2]) : ((f == 1) ? qmul(c[0], c[2]) : qmul(c[0], c[1]));
        frc = clamp46(qmul(dv, clamp32(dp)));
        res[f] = clamp32(lap - clamp46(qmul(c[f], coef[CFG_MASS_SQ])) - frc + cu);
      end else begin
        res[f] = clamp32(lap - clamp46(qmul(c[f], coef[CFG_THETA_MASS_SQ])) + cu);
      end
    end
    r.out_voxel = v;
    r.res_phi_x = q16_t'(res[0]);
    r.res_phi_y = q16_t'(res[1]);
    r.res_phi_z = q16_t'(res[2]);
    r.res_theta_x = q16_t'(res[3]);
    r.res_theta_y = q16_t'(res[4]);
    r.res_theta_z = q16_t'(res[5]);
    return r;
  endfunction

  // Field values: mostly small magnitudes, with extremes and full-range noise.
  function automatic q16_t rand_q();
    case ($urandom_range(0, 9))
      0: return QMAX;
      1: return QMIN;
      2, 3: return q16_t'($urandom);
      default: return q16_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
  endfunction

  function automatic in_item_t rand_word(op_t op, logic [14:0] v);
    in_item_t w;
    w.op = op;
    w.voxel = v;
    w.phi_x = rand_q();
    w.phi_y = rand_q();
    w.phi_z = rand_q();
    w.theta_x = rand_q();
    w.theta_y = rand_q();
    w.theta_z = rand_q();
    return w;
  endfunction

  // Offers one word, waits for it to be taken, and updates the predictor.
  task automatic send_word(in_item_t w, bit typed, q16_t typed_res);
    out_item_t e;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (w.op == OP_WRITE) begin
      field_mem[w.voxel] = '{w.phi_x, w.phi_y, w.phi_z, w.theta_x, w.theta_y, w.theta_z};
      voxel_written[w.voxel] = 1'b1;
    end else begin
      if (typed) begin
        e.out_voxel = w.voxel;
        e.res_phi_x = typed_res;
        e.res_phi_y = typed_res;
        e.res_phi_z = typed_res;
        e.res_theta_x = typed_res;
        e.res_theta_y = typed_res;
        e.res_theta_z = typed_res;
      end else begin
        e = predict_residuals(w.voxel);
      end
      pending_res.push_back(e);
    end
  endtask

  // Writes each of the center and its neighbors that has never been written.
  task automatic fill_neighborhood(logic [14:0] v);
    for (int n = 0; n <= 6; n++)
      if (!voxel_written[nb_of(v, n)]) send_word(rand_word(OP_WRITE, nb_of(v, n)), 1'b0, '0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx <= CFG_INV_TWO_SPACING)
      coef[idx] = (idx >= CFG_INV_SPACING_SQ) ? longint'(val[30:0]) : longint'(int'(val));
  endtask

  // Lets the block go quiet: all results back, then a settling pause.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_coefs(int ph);
    logic [31:0] v [7];
    case (ph)
      1: v = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF};
      2: v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h0000_0000};
      3: foreach (v[n]) v[n] = $urandom;
      default: v = '{32'd65536, 32'd32768, -32'sd196608, 32'd65536, 32'd65536,
                     32'd262144, 32'd65536};
    endcase
    write_reg(CFG_MASS_SQ, v[0]);
    write_reg(CFG_THETA_MASS_SQ, v[1]);
    write_reg(CFG_POT_COUPLING, v[2]);
    write_reg(CFG_POT_SATURATION, v[3]);
    write_reg(CFG_CURL_COUPLING, v[4]);
    write_reg(CFG_INV_SPACING_SQ, v[5]);
    write_reg(CFG_INV_TWO_SPACING, v[6]);
    // An index past the last register must leave every coefficient alone.
    if (ph == 1) write_reg(CFG_UNUSED, $urandom);
  endtask

  initial begin
    forever #6 clk = ~clk;
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic cmp_field(string name, longint e, longint a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      errors++;
    end
  endtask

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk) begin : result_check
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_res.size() == 0) begin
        $error("unexpected result word for voxel %0d", out_data.out_voxel);
        errors++;
      end else begin
        e = pending_res.pop_front();
        cmp_field("out_voxel", e.out_voxel, out_data.out_voxel);
        cmp_field("res_phi_x", e.res_phi_x, out_data.res_phi_x);
        cmp_field("res_phi_y", e.res_phi_y, out_data.res_phi_y);
        cmp_field("res_phi_z", e.res_phi_z, out_data.res_phi_z);
        cmp_field("res_theta_x", e.res_theta_x, out_data.res_theta_x);
        cmp_field("res_theta_y", e.res_theta_y, out_data.res_theta_y);
        cmp_field("res_theta_z", e.res_theta_z, out_data.res_theta_z);
      end
    end
  end

  // Watchdog: too long without any word moving on any channel ends the run.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    logic [14:0] hot [8];
    logic [14:0] v;
    in_item_t w;
    int target;
    int r;
    coef = '{147456, 0, -2709586, 3276800, 32768, 65536, 32768};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part runs on the reset coefficients.
    foreach (DIR[n]) begin
      w = '{DIR[n].op, DIR[n].vox, DIR[n].phi, DIR[n].phi, DIR[n].phi,
            DIR[n].theta, DIR[n].theta, DIR[n].theta};
      send_word(w, DIR[n].typed, DIR[n].res);
    end

    // Random phases, each under its own coefficient setting.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        load_coefs(ph);
      end
      if (ph == NUM_PHASES - 1) idle_on = 1'b0;
      if (ph == 2) long_hold = 1'b1;
      foreach (hot[n]) hot[n] = 15'($urandom);
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) begin
        r = $urandom_range(0, 9);
        if (r < 2) begin
          // Stray write anywhere in the grid.
          send_word(rand_word(OP_WRITE, 15'($urandom)), 1'b0, '0);
        end else begin
          // Half of the queries cluster around eight hot spots so that neighborhoods overlap.
          v = $urandom_range(0, 1) ? 15'($urandom) : nb_of(hot[$urandom_range(0, 7)],
                                                            $urandom_range(0, 6));
          fill_neighborhood(v);
          if (r == 2) send_word(rand_word(OP_WRITE, nb_of(v, $urandom_range(0, 6))), 1'b0, '0);
          send_word(rand_word(OP_QUERY, v), 1'b0, '0);
        end
      end
    end

    drain();
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
